@@ rtl/core/ntrd_pkg.sv @@
// ----------------------------------------------------------------------------
// ntrd_pkg
// Shared types and constants for the nibble table run decompressor.
// ----------------------------------------------------------------------------
package ntrd_pkg;

   localparam int TABLE_LOW_W   = 64;
   localparam int TABLE_HIGH_W  = 40;
   localparam int TABLE_W       = TABLE_LOW_W + TABLE_HIGH_W;
   localparam int CSR_DATA_W    = 64;
   localparam int COUNT_W       = 5;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [3:0]         ESC_REPEAT  = 4'hE;
   localparam logic [3:0]         ESC_RAW     = 4'hF;
   localparam logic [COUNT_W-1:0] REPEAT_BIAS = 5'd2;
   localparam logic [COUNT_W-1:0] MAX_RUN     = 5'd17;

   // Configuration register indexes.
   localparam logic CSR_CODE_TABLE_LOW  = 1'b0;
   localparam logic CSR_CODE_TABLE_HIGH = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_RAW_LO      = 3'd1,
      PH_RAW_HI      = 3'd2,
      PH_REP_CNT     = 3'd3,
      PH_REP_SYM     = 3'd4,
      PH_REP_RAW_LO  = 3'd5,
      PH_REP_RAW_HI  = 3'd6
   } phase_type;

   // One queued item: the byte and run length caused by each nibble.
   typedef struct packed {
      logic [7:0]         value0;
      logic [COUNT_W-1:0] count0;
      logic [7:0]         value1;
      logic [COUNT_W-1:0] count1;
   } run_cmd_type;

endpackage

@@ rtl/core/ntrd_front.sv @@
// ----------------------------------------------------------------------------
// ntrd_front
// Accepts packed bytes, tracks the escape state and turns each item into
// at most two runs for the back end.
// ----------------------------------------------------------------------------
module ntrd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_packed_byte,
   input  logic                          req_start_topic,
   input  logic [ntrd_pkg::TABLE_W-1:0]  code_table,
   input  logic                          q_full,
   output logic                          q_push,
   output ntrd_pkg::run_cmd_type         q_push_data
);
   import ntrd_pkg::*;

   typedef struct packed {
      phase_type          phase;
      logic [COUNT_W-1:0] repeat_count;
      logic [3:0]         raw_low;
   } dec_state_type;

   typedef struct packed {
      dec_state_type      next;
      logic [7:0]         value;
      logic [COUNT_W-1:0] count;
   } nib_result_type;

   function automatic logic [7:0] table_byte(logic [3:0] code, logic [TABLE_W-1:0] tbl);
      logic [3:0] idx;
      logic [7:0] res;
      idx = code - 4'd1;
      res = 8'd0;
      if (code >= 4'd1 && code <= 4'd13) begin
         res = tbl[{idx, 3'b000} +: 8];
      end
      return res;
   endfunction

   function automatic nib_result_type decode_nib(dec_state_type s, logic [3:0] nib,
                                                 logic [TABLE_W-1:0] tbl);
      nib_result_type r;
      r.next  = s;
      r.value = 8'd0;
      r.count = '0;
      case (s.phase)
         PH_RAW_LO: begin
            r.next.raw_low = nib;
            r.next.phase   = PH_RAW_HI;
         end
         PH_RAW_HI: begin
            r.value      = {nib, s.raw_low};
            r.count      = COUNT_W'(1);
            r.next.phase = PH_IDLE;
         end
         PH_REP_CNT: begin
            r.next.repeat_count = {1'b0, nib} + REPEAT_BIAS;
            r.next.phase        = PH_REP_SYM;
         end
         PH_REP_SYM: begin
            if (nib == ESC_RAW) begin
               r.next.phase = PH_REP_RAW_LO;
            end else begin
               if (nib != ESC_REPEAT) begin
                  r.value = table_byte(nib, tbl);
                  r.count = s.repeat_count;
               end
               r.next.phase = PH_IDLE;
            end
         end
         PH_REP_RAW_LO: begin
            r.next.raw_low = nib;
            r.next.phase   = PH_REP_RAW_HI;
         end
         PH_REP_RAW_HI: begin
            r.value      = {nib, s.raw_low};
            r.count      = s.repeat_count;
            r.next.phase = PH_IDLE;
         end
         default: begin
            // No escape pending; the unused phase code behaves the same way.
            if (nib == ESC_REPEAT) begin
               r.next.phase = PH_REP_CNT;
            end else if (nib == ESC_RAW) begin
               r.next.phase = PH_RAW_LO;
            end else begin
               r.next.phase = PH_IDLE;
               r.value      = table_byte(nib, tbl);
               r.count      = COUNT_W'(1);
            end
         end
      endcase
      return r;
   endfunction

   dec_state_type  state_ff;
   dec_state_type  state_in;
   dec_state_type  start_state;
   nib_result_type low_res;
   nib_result_type high_res;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, repeat_count: '0, raw_low: '0};
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_ready = !q_full;
      accept    = req_valid && req_ready;

      start_state = state_ff;
      if (req_start_topic) begin
         start_state = '{phase: PH_IDLE, repeat_count: '0, raw_low: '0};
      end

      low_res  = decode_nib(start_state, req_packed_byte[3:0], code_table);
      high_res = decode_nib(low_res.next, req_packed_byte[7:4], code_table);

      state_in = accept ? high_res.next : state_ff;

      q_push_data.value0 = low_res.value;
      q_push_data.count0 = low_res.count;
      q_push_data.value1 = high_res.value;
      q_push_data.count1 = high_res.count;
      // Items that cause no byte never reach the queue.
      q_push = accept && (low_res.count != '0 || high_res.count != '0);
   end

endmodule

@@ rtl/core/ntrd_queue.sv @@
// ----------------------------------------------------------------------------
// ntrd_queue
// Small register queue of runs between the front and the back end.
// ----------------------------------------------------------------------------
module ntrd_queue #(
   parameter int DEPTH = ntrd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ntrd_pkg::run_cmd_type  push_data,
   output logic                   full,
   input  logic                   pop,
   output ntrd_pkg::run_cmd_type  head,
   output logic                   empty
);
   import ntrd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   run_cmd_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      empty     = (count_ff == '0);
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/ntrd_back.sv @@
// ----------------------------------------------------------------------------
// ntrd_back
// Expands queued runs into one output byte per cycle while rsp_ready is high,
// through an output register, marking the final byte of each item.
// ----------------------------------------------------------------------------
module ntrd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  ntrd_pkg::run_cmd_type  q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_text_byte,
   output logic                   rsp_last_of_run
);
   import ntrd_pkg::*;

   logic [7:0]         value0_ff, value0_in;
   logic [7:0]         value1_ff, value1_in;
   logic [COUNT_W-1:0] count0_ff, count0_in;
   logic [COUNT_W-1:0] count1_ff, count1_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_text_ff, rsp_text_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               work_empty;
   logic               out_free;
   logic               emit;
   logic [7:0]         emit_value;
   logic               emit_last;

   always_comb begin
      work_empty = (count0_ff == '0) && (count1_ff == '0);
      out_free   = !rsp_valid_ff || rsp_ready;
      emit       = out_free && !work_empty;

      if (count0_ff != '0) begin
         emit_value = value0_ff;
         emit_last  = (count0_ff == COUNT_W'(1)) && (count1_ff == '0);
      end else begin
         emit_value = value1_ff;
         emit_last  = (count1_ff == COUNT_W'(1));
      end

      value0_in = value0_ff;
      value1_in = value1_ff;
      count0_in = count0_ff;
      count1_in = count1_ff;
      if (emit) begin
         if (count0_ff != '0) begin
            count0_in = count0_ff - 1'b1;
         end else begin
            count1_in = count1_ff - 1'b1;
         end
      end

      // The next run is loaded as soon as the current one has sent its last byte.
      q_pop = !q_empty && (work_empty || (emit && emit_last));
      if (q_pop) begin
         value0_in = q_head.value0;
         count0_in = q_head.count0;
         value1_in = q_head.value1;
         count1_in = q_head.count1;
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
      rsp_text_in  = emit ? emit_value : rsp_text_ff;
      rsp_last_in  = emit ? emit_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count0_ff    <= '0;
         count1_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count0_ff    <= count0_in;
         count1_ff    <= count1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value0_ff   <= value0_in;
      value1_ff   <= value1_in;
      rsp_text_ff <= rsp_text_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text_byte   = rsp_text_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_run_ends_clean : assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last && !q_pop) |=> work_empty)
      else $error("run counters not drained after the last byte of an item");

   a_run_bounded : assert property (@(posedge clock) disable iff (reset)
      (count0_ff <= MAX_RUN) && (count1_ff <= MAX_RUN))
      else $error("run length out of range");

   a_no_empty_runs : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_head.count0 != '0 || q_head.count1 != '0))
      else $error("queue delivered an item that causes no byte");

endmodule

@@ rtl/core/nibble_table_run_decompressor.sv @@
// ----------------------------------------------------------------------------
// nibble_table_run_decompressor
// Decodes two code nibbles per packed byte into text bytes, with table
// lookup, raw bytes and repeat runs, one output byte per result.
// ----------------------------------------------------------------------------
// The first result of an item passes the front decode into the queue, the
// back-end load and the output register after the item is accepted.
// Throughput: the back end sends one result per cycle while rsp_ready is
// high, so a run of up to 17 bytes stalls the input once the run queue is
// full. Items that cause no byte never enter the run queue.
// Reset clears the code tables, the escape state, the run queue and the
// output valid; the block is ready for an item as soon as reset is released.
module nibble_table_run_decompressor #(
   parameter int QUEUE_DEPTH = ntrd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_packed_byte,
   input  logic                             req_start_topic,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_text_byte,
   output logic                             rsp_last_of_run,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [ntrd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ntrd_pkg::*;

   // Code table registers. Code 1 sits in the lowest byte of the low word,
   // code 9 in the lowest byte of the high word; codes 0, 14 and 15 never
   // read the table.
   logic [TABLE_LOW_W-1:0]  table_low_ff, table_low_in;
   logic [TABLE_HIGH_W-1:0] table_high_ff, table_high_in;

   // Run queue between the decoder front and the byte expander.
   logic        q_full;
   logic        q_push;
   run_cmd_type q_push_data;
   logic        q_pop;
   run_cmd_type q_head;
   logic        q_empty;

   // Configuration writes are always taken at once. Bits above the 40
   // meaningful ones of the high table word are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      table_low_in  = table_low_ff;
      table_high_in = table_high_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CODE_TABLE_LOW:  table_low_in  = csr_data;
            CSR_CODE_TABLE_HIGH: table_high_in = csr_data[TABLE_HIGH_W-1:0];
            default:             table_low_in  = table_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_low_ff  <= '0;
         table_high_ff <= '0;
      end else begin
         table_low_ff  <= table_low_in;
         table_high_ff <= table_high_in;
      end
   end

   // The front end decodes both nibbles of an item in the cycle it is accepted;
   // the escape state carries across items until req_start_topic clears it.
   ntrd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_packed_byte (req_packed_byte),
      .req_start_topic (req_start_topic),
      .code_table      ({table_high_ff, table_low_ff}),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_push_data     (q_push_data)
   );

   ntrd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // The back end repeats each run's byte and flags the final byte of the item.
   ntrd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_text_byte   (rsp_text_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
